[rtl/gkia_pkg.sv]
// Shared types and constants for the group key index assigner.
package gkia_pkg;

  localparam int unsigned KEY_FIELD_W = 64;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned GROUP_W     = 11;
  localparam int unsigned MAX_GROUPS  = 1024;

  localparam logic [GROUP_W-1:0] MAX_IDX = GROUP_W'(MAX_GROUPS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_NULL,
    S_CHECK
  } gkia_state_e;

  typedef struct packed {
    logic                   mode;
    logic                   row_passes;
    logic                   key_present;
    logic [KEY_FIELD_W-1:0] key_value;
    logic [ROW_W-1:0]       row_number;
  } gkia_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_out;
    logic [GROUP_W-1:0] group_index;
    logic               first_seen;
    logic               table_full;
  } gkia_out_t;

endpackage

[rtl/group_key_index_assigner_top.sv]
// Group key index assigner: dense group index per key over a linear-probe hash table.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one transaction per row or
// clear command. A row that passes the filter gives one transaction on the output
// channel (out_valid_o/out_ready_i/out_data_o) with its group index; filtered rows
// and clear commands give none.
// A row is accepted in S_IDLE, which reads its home slot through the slot memory's
// single read port. In S_CHECK a hit, an empty slot or the last probe loads the
// result into the output register once that is free; else the next slot is read,
// one slot per cycle. A null key goes to S_NULL. The next row is taken in S_IDLE.
// Reset and the clear command both start a sweep that zeroes every slot, one slot
// per cycle; in_ready_o stays low during the sweep.
// The result sits in an output register, so the next row is accepted while a
// result waits. When the receiver stalls and a new result is ready, the block
// holds the finished lookup until the output register frees up.
// When the index counter reaches MAX_GROUPS or no empty slot is left, a new key
// gets group index 0 with table_full set; known keys keep their index.
module group_key_index_assigner_top
  import gkia_pkg::*;
#(
  parameter int unsigned KEY_WIDTH   = 64,
  parameter int unsigned TABLE_SLOTS = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gkia_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gkia_out_t out_data_o
);

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned ENTRY_W = KEY_WIDTH + GROUP_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W:0]   NUM_SLOTS = (SLOT_W + 1)'(TABLE_SLOTS);

  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_WIDTH-1:0] k);
    logic [SLOT_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_WIDTH; i++) begin
      h[i % SLOT_W] = h[i % SLOT_W] ^ k[i];
    end
    if ({1'b0, h} >= NUM_SLOTS) begin
      h = h - NUM_SLOTS[SLOT_W-1:0];
    end
    return h;
  endfunction

  gkia_state_e        state_q, state_d;
  gkia_in_t           item_q, item_d;
  logic [SLOT_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0]  probe_q, probe_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;
  logic [GROUP_W-1:0] last_q, last_d;
  logic [GROUP_W-1:0] null_q, null_d;
  logic               out_valid_q, out_valid_d;
  gkia_out_t          out_data_q;
  gkia_out_t          res;
  logic               load;

  logic [ENTRY_W-1:0] slot_mem [TABLE_SLOTS];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic               in_acc;
  logic               out_free;
  logic [GROUP_W-1:0] entry_grp;
  logic [KEY_WIDTH-1:0] entry_key;
  logic [KEY_WIDTH-1:0] item_key;
  logic               slot_empty;
  logic               key_hit;
  logic               last_probe;
  logic               groups_out;
  logic [SLOT_W-1:0]  next_pos;
  logic [GROUP_W-1:0] new_idx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign entry_grp   = rd_data_q[GROUP_W-1:0];
  assign entry_key   = rd_data_q[ENTRY_W-1:GROUP_W];
  assign item_key    = item_q.key_value[KEY_WIDTH-1:0];
  assign slot_empty  = (entry_grp == '0);
  assign key_hit     = !slot_empty && (entry_key == item_key);
  assign last_probe  = (probe_q == LAST_SLOT);
  assign groups_out  = (last_q >= MAX_IDX);
  assign next_pos    = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
  assign new_idx     = last_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_SLOT) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_data_i.mode)        state_d = S_CLEAR;
          else if (!in_data_i.row_passes)     state_d = S_IDLE;
          else if (!in_data_i.key_present)    state_d = S_NULL;
          else                                state_d = S_CHECK;
        end
      end
      S_NULL: begin
        if (out_free) state_d = S_IDLE;
      end
      S_CHECK: begin
        if ((slot_empty || key_hit || last_probe) && out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    item_d    = item_q;
    pos_d     = pos_q;
    probe_d   = probe_q;
    clr_d     = clr_q;
    last_d    = last_q;
    null_d    = null_q;
    load      = 1'b0;
    res       = '0;
    res.row_out = item_q.row_number;
    rd_en     = 1'b0;
    rd_addr   = pos_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = (clr_q == LAST_SLOT) ? '0 : clr_q + 1'b1;
      end
      S_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = home_slot(in_data_i.key_value[KEY_WIDTH-1:0]);
        if (in_acc) begin
          item_d  = in_data_i;
          pos_d   = rd_addr;
          probe_d = '0;
          if (in_data_i.mode) begin
            last_d = '0;
            null_d = '0;
            clr_d  = '0;
          end
        end
      end
      S_NULL: begin
        if (out_free) begin
          load = 1'b1;
          priority if (null_q != '0) begin
            res.group_index = null_q;
          end else if (groups_out) begin
            res.table_full = 1'b1;
          end else begin
            last_d          = new_idx;
            null_d          = new_idx;
            res.group_index = new_idx;
            res.first_seen  = 1'b1;
          end
        end
      end
      S_CHECK: begin
        priority if (slot_empty) begin
          if (out_free) begin
            load = 1'b1;
            if (groups_out) begin
              res.table_full = 1'b1;
            end else begin
              mem_we          = 1'b1;
              mem_wdata       = {item_key, new_idx};
              last_d          = new_idx;
              res.group_index = new_idx;
              res.first_seen  = 1'b1;
            end
          end
        end else if (key_hit) begin
          if (out_free) begin
            load            = 1'b1;
            res.group_index = entry_grp;
          end
        end else if (last_probe) begin
          if (out_free) begin
            load           = 1'b1;
            res.table_full = 1'b1;
          end
        end else begin
          pos_d   = next_pos;
          probe_d = probe_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = next_pos;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      last_q      <= '0;
      null_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      last_q      <= last_d;
      null_q      <= null_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    pos_q   <= pos_d;
    probe_q <= probe_d;
    if (load) out_data_q <= res;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= slot_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_last_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q <= MAX_IDX)
    else $error("index counter beyond MAX_GROUPS");

  a_null_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    null_q <= last_q)
    else $error("null group index beyond last index handed out");

  a_first_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && res.first_seen |=> last_q == out_data_q.group_index)
    else $error("new group index does not match counter");

  a_full_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.table_full |->
      out_data_o.group_index == '0 && !out_data_o.first_seen)
    else $error("flagged result carries an index");

endmodule

[verif/group_key_index_assigner_top_test.sv]
// Self-checking testbench for the group key index assigner: directed table, random rows, scoreboard.
module group_key_index_assigner_top_test;
  import gkia_pkg::*;

  localparam int unsigned KEY_WIDTH   = 64;
  localparam int unsigned TABLE_SLOTS = 2048;
  localparam logic [KEY_FIELD_W-1:0] KEY_MASK =
    {KEY_FIELD_W{1'b1}} >> (KEY_FIELD_W - KEY_WIDTH);
  localparam logic [KEY_FIELD_W-1:0] KEY_ONES = {KEY_FIELD_W{1'b1}};

  localparam logic MODE_MAP   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int MIX_ROWS     = 300;
  localparam int FULL_TAIL    = 120;

  localparam gkia_out_t NO_RESULT = '0;

  typedef struct {
    gkia_in_t  item;
    bit        typed;
    gkia_out_t want;
  } script_row_t;

  script_row_t script [24] = '{
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h0, 16'h0000}, 1'b1, '{16'h0000, 11'd1, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, KEY_ONES, 16'hFFFF}, 1'b1, '{16'hFFFF, 11'd2, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h0, 16'h0001}, 1'b1, '{16'h0001, 11'd1, 1'b0, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b0, 64'h123456789ABCDEF0, 16'h0002}, 1'b1,
      '{16'h0002, 11'd3, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b0, KEY_ONES, 16'h0003}, 1'b1, '{16'h0003, 11'd3, 1'b0, 1'b0}},
    '{'{MODE_MAP, 1'b0, 1'b1, 64'h5555555555555555, 16'h0004}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b0, 1'b0, 64'h0, 16'h0005}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'hAAAAAAAAAAAAAAAA, 16'h8000}, 1'b1,
      '{16'h8000, 11'd4, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h5555555555555555, 16'h7FFF}, 1'b1,
      '{16'h7FFF, 11'd5, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, KEY_ONES, 16'h1234}, 1'b1, '{16'h1234, 11'd2, 1'b0, 1'b0}},
    '{'{MODE_CLEAR, 1'b1, 1'b1, KEY_ONES, 16'hFFFF}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b1, 1'b1, KEY_ONES, 16'h0010}, 1'b1, '{16'h0010, 11'd1, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h0, 16'h0011}, 1'b1, '{16'h0011, 11'd2, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b0, 64'h0, 16'h0012}, 1'b1, '{16'h0012, 11'd3, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h8000000000000000, 16'h0013}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h1, 16'h0014}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h2, 16'h0015}, 1'b0, NO_RESULT},
    '{'{MODE_CLEAR, 1'b0, 1'b0, 64'h0, 16'h0000}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b1, 1'b0, 64'h0, 16'hFFFF}, 1'b1, '{16'hFFFF, 11'd1, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h0, 16'h0020}, 1'b1, '{16'h0020, 11'd2, 1'b1, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b0, 64'h5555, 16'h0021}, 1'b1, '{16'h0021, 11'd1, 1'b0, 1'b0}},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h00000000FFFFFFFF, 16'h0022}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'hFFFFFFFF00000000, 16'h0023}, 1'b0, NO_RESULT},
    '{'{MODE_MAP, 1'b1, 1'b1, 64'h00000000FFFFFFFF, 16'h0024}, 1'b0, NO_RESULT}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  gkia_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  gkia_out_t out_data_o;

  logic [GROUP_W-1:0]   group_of_key [bit [KEY_FIELD_W-1:0]];
  bit [KEY_FIELD_W-1:0] known_keys [$];
  int unsigned          groups_issued = 0;
  logic [GROUP_W-1:0]   null_group = '0;
  gkia_out_t            pending_groups [$];
  int                   mismatches = 0;
  int                   rows_sent = 0;
  bit                   idle_tx = 1'b1;
  int                   cycles = 0;

  group_key_index_assigner_top #(
    .KEY_WIDTH  (KEY_WIDTH),
    .TABLE_SLOTS(TABLE_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("[group_key_index_assigner_top] ERROR");
      $finish;
    end
  end

  function automatic bit map_row(input gkia_in_t item, output gkia_out_t res);
    bit [KEY_FIELD_W-1:0] key;
    res = '0;
    res.row_out = item.row_number;
    if (item.mode == MODE_CLEAR) begin
      group_of_key.delete();
      known_keys.delete();
      groups_issued = 0;
      null_group = '0;
      return 1'b0;
    end
    if (!item.row_passes) return 1'b0;
    if (!item.key_present) begin
      if (null_group != '0) begin
        res.group_index = null_group;
      end else if (groups_issued >= MAX_GROUPS) begin
        res.table_full = 1'b1;
      end else begin
        groups_issued++;
        null_group = GROUP_W'(groups_issued);
        res.group_index = null_group;
        res.first_seen = 1'b1;
      end
      return 1'b1;
    end
    key = item.key_value & KEY_MASK;
    if (group_of_key.exists(key)) begin
      res.group_index = group_of_key[key];
    end else if (groups_issued >= MAX_GROUPS) begin
      res.table_full = 1'b1;
    end else begin
      groups_issued++;
      group_of_key[key] = GROUP_W'(groups_issued);
      known_keys.push_back(key);
      res.group_index = GROUP_W'(groups_issued);
      res.first_seen = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic gkia_in_t random_row();
    gkia_in_t item;
    item.mode        = 1'($urandom);
    item.row_passes  = 1'($urandom);
    item.key_present = 1'($urandom);
    item.key_value   = {$urandom, $urandom};
    item.row_number  = 16'($urandom);
    return item;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got, input int unsigned row);
    if (want != got) begin
      $display("%0t row %0d %s: expected %0d, actual %0d", $time, row, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_row(input gkia_in_t item, input bit typed = 1'b0,
                          input gkia_out_t typed_res = '0);
    int        gap;
    gkia_out_t res;
    if (rows_sent % 64 == 0) idle_tx = ($urandom_range(0, 3) != 0);
    rows_sent++;
    gap = idle_tx ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (map_row(item, res)) pending_groups.push_back(typed ? typed_res : res);
  endtask

  initial begin : result_sink
    int        stall;
    int        taken;
    bit        idle_rx;
    gkia_out_t want;
    taken = 0;
    idle_rx = 1'b1;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 50 == 0) idle_rx = ($urandom_range(0, 3) != 0);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      else stall = idle_rx ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (pending_groups.size() == 0) begin
        $display("%0t unexpected transaction: row %0d index %0d", $time,
                 out_data_o.row_out, out_data_o.group_index);
        mismatches++;
      end else begin
        want = pending_groups.pop_front();
        check_field("row_out", want.row_out, out_data_o.row_out, want.row_out);
        check_field("group_index", want.group_index, out_data_o.group_index, want.row_out);
        check_field("first_seen", want.first_seen, out_data_o.first_seen, want.row_out);
        check_field("table_full", want.table_full, out_data_o.table_full, want.row_out);
      end
    end
  end

  initial begin : row_source
    gkia_in_t item;
    int       pick;
    int       tail;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_row(script[i].item, script[i].typed, script[i].want);

    // fill the index space, then keep offering new, known and null keys past exhaustion
    tail = 0;
    while (tail < FULL_TAIL) begin
      item = random_row();
      pick = $urandom_range(0, 99);
      item.mode = MODE_MAP;
      item.row_passes = (pick >= 8);
      if (pick >= 8) item.key_present = 1'b1;
      if (pick >= 8 && pick < 20 && known_keys.size() > 0)
        item.key_value = known_keys[$urandom_range(0, known_keys.size() - 1)];
      if (groups_issued >= MAX_GROUPS) begin
        tail++;
        if (pick >= 70) item.key_present = 1'b0;
      end
      send_row(item);
    end

    item = random_row();
    item.mode = MODE_CLEAR;
    send_row(item);

    repeat (MIX_ROWS) begin
      item = random_row();
      pick = $urandom_range(0, 99);
      if (pick >= 3) begin
        item.mode = MODE_MAP;
        item.row_passes = (pick >= 11);
        if (pick >= 11) item.key_present = (pick >= 26);
        if (pick >= 26 && pick < 66 && known_keys.size() > 0)
          item.key_value = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else if (pick >= 66 && pick < 83)
          item.key_value = KEY_FIELD_W'($urandom_range(0, 63));
      end else begin
        item.mode = MODE_CLEAR;
      end
      send_row(item);
    end

    in_valid_i <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[group_key_index_assigner_top] OK");
    end else begin
      $display("[group_key_index_assigner_top] ERROR");
    end
    $finish;
  end

endmodule

[group_key_index_assigner_top.f]
rtl/gkia_pkg.sv
rtl/group_key_index_assigner_top.sv
verif/group_key_index_assigner_top_test.sv
